// ===== src/cps_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cps_pkg: shared definitions for the closest point on segment block
// Widths, constants and the stage record that travels down the divider chain.
// ---------------------------------------------------------------------------
package cps_pkg;

    localparam int COORD_BITS     = 16;
    localparam int RATE_FRAC_BITS = 16;
    localparam int RATE_BITS      = RATE_FRAC_BITS + 1;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int SUM_BITS       = PROD_BITS + 2;
    localparam int MUL_BITS       = DIFF_BITS + RATE_BITS + 1;

    localparam logic [RATE_BITS-1:0] RATE_ONE  = RATE_BITS'(1) << RATE_FRAC_BITS;
    localparam logic [RATE_BITS-1:0] RATE_ZERO = '0;
    localparam logic [MUL_BITS-1:0]  ROUND_HALF = MUL_BITS'(1) << (RATE_FRAC_BITS - 1);

    typedef enum logic [2:0] {
        SEL_ZERO = 3'b001,
        SEL_ONE  = 3'b010,
        SEL_DIV  = 3'b100
    } rate_sel_t;

    typedef struct packed {
        logic                                valid;
        logic [2:0][COORD_BITS-1:0]          start;
        logic [2:0][DIFF_BITS-1:0]           diff;
        logic [SUM_BITS-1:0]                 rem;
        logic [SUM_BITS-1:0]                 den;
        logic [RATE_FRAC_BITS-1:0]           quo;
        rate_sel_t                           sel;
        logic                                on_segment;
        logic                                degenerate;
    } cps_stage_t;

endpackage

// ===== src/cps_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cps_if: query and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ---------------------------------------------------------------------------
interface cps_in_if
    import cps_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_start_z;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] seg_end_z;

    modport source (
        output valid, point_x, point_y, point_z,
               seg_start_x, seg_start_y, seg_start_z,
               seg_end_x, seg_end_y, seg_end_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z,
               seg_start_x, seg_start_y, seg_start_z,
               seg_end_x, seg_end_y, seg_end_z,
        output ready
    );
endinterface

interface cps_out_if
    import cps_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic        [RATE_BITS-1:0]  clamped_rate;
    logic                         on_segment;
    logic                         degenerate;

    modport source (
        output valid, near_x, near_y, near_z, clamped_rate, on_segment, degenerate,
        input  ready
    );
    modport sink (
        input  valid, near_x, near_y, near_z, clamped_rate, on_segment, degenerate,
        output ready
    );
endinterface

// ===== src/cps_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cps_front: difference, product and sum stages
// Forms the segment direction, the dot product and the squared length, and
// classifies the parameter before it enters the divider chain.
// ---------------------------------------------------------------------------
module cps_front
    import cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    cps_in_if.sink      query,
    output cps_stage_t  stage_out
);

    logic                                valid1_reg;
    logic [2:0][COORD_BITS-1:0]          start1_reg;
    logic [2:0][DIFF_BITS-1:0]           diff1_reg;
    logic [2:0][DIFF_BITS-1:0]           vec1_reg;
    logic [2:0][DIFF_BITS-1:0]           diff1_next;
    logic [2:0][DIFF_BITS-1:0]           vec1_next;
    logic [2:0][COORD_BITS-1:0]          pt;
    logic [2:0][COORD_BITS-1:0]          st;
    logic [2:0][COORD_BITS-1:0]          en;

    logic                                valid2_reg;
    logic [2:0][COORD_BITS-1:0]          start2_reg;
    logic [2:0][DIFF_BITS-1:0]           diff2_reg;
    logic [2:0][PROD_BITS-1:0]           dv2_reg;
    logic [2:0][PROD_BITS-1:0]           dd2_reg;
    logic [2:0][PROD_BITS-1:0]           dv2_next;
    logic [2:0][PROD_BITS-1:0]           dd2_next;

    logic signed [SUM_BITS-1:0]          dot;
    logic signed [SUM_BITS-1:0]          len2;
    logic                                valid3_reg;
    cps_stage_t                          stage_reg;
    cps_stage_t                          stage_next;

    assign query.ready = advance;

    assign pt = {query.point_z, query.point_y, query.point_x};
    assign st = {query.seg_start_z, query.seg_start_y, query.seg_start_x};
    assign en = {query.seg_end_z, query.seg_end_y, query.seg_end_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff1_next[i] = {en[i][COORD_BITS-1], en[i]} - {st[i][COORD_BITS-1], st[i]};
            vec1_next[i]  = {pt[i][COORD_BITS-1], pt[i]} - {st[i][COORD_BITS-1], st[i]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv2_next[i] = PROD_BITS'($signed(diff1_reg[i]) * $signed(vec1_reg[i]));
            dd2_next[i] = PROD_BITS'($signed(diff1_reg[i]) * $signed(diff1_reg[i]));
        end
    end

    always_comb
    begin
        dot  = SUM_BITS'($signed(dv2_reg[0])) + SUM_BITS'($signed(dv2_reg[1]))
             + SUM_BITS'($signed(dv2_reg[2]));
        len2 = SUM_BITS'($signed(dd2_reg[0])) + SUM_BITS'($signed(dd2_reg[1]))
             + SUM_BITS'($signed(dd2_reg[2]));

        stage_next            = stage_reg;
        stage_next.valid      = valid2_reg;
        stage_next.start      = start2_reg;
        stage_next.diff       = diff2_reg;
        stage_next.rem        = dot;
        stage_next.den        = len2;
        stage_next.quo        = '0;
        stage_next.degenerate = (len2 == '0);
        stage_next.on_segment = (len2 != '0) && (dot >= 0) && (dot <= len2);
        priority if (len2 == '0)
            stage_next.sel = SEL_ONE;
        else if (dot <= 0)
            stage_next.sel = SEL_ZERO;
        else if (dot >= len2)
            stage_next.sel = SEL_ONE;
        else
            stage_next.sel = SEL_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= query.valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            start1_reg <= st;
            diff1_reg  <= diff1_next;
            vec1_reg   <= vec1_next;
            start2_reg <= start1_reg;
            diff2_reg  <= diff1_reg;
            dv2_reg    <= dv2_next;
            dd2_reg    <= dd2_next;
            stage_reg  <= stage_next;
        end
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid3_reg;
    end

endmodule

// ===== src/cps_div_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cps_div_cell: one restoring division step
// Shifts the remainder, subtracts the squared length when it fits and appends
// one quotient bit, then hands the record to the next cell.
// ---------------------------------------------------------------------------
module cps_div_cell
    import cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  cps_stage_t  stage_in,
    output cps_stage_t  stage_out
);

    logic                valid_reg;
    cps_stage_t          stage_reg;
    cps_stage_t          stage_next;
    logic [SUM_BITS-1:0] shifted;
    logic                fits;

    always_comb
    begin
        shifted        = {stage_in.rem[SUM_BITS-2:0], 1'b0};
        fits           = (shifted >= stage_in.den);
        stage_next     = stage_in;
        stage_next.rem = fits ? (shifted - stage_in.den) : shifted;
        stage_next.quo = {stage_in.quo[RATE_FRAC_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= stage_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            stage_reg <= stage_next;
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ===== src/cps_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cps_back: rate selection, scaling and output register
// Picks the clamped rate, scales the direction by it, rounds and offsets the
// start point, and holds the result until it is taken.
// ---------------------------------------------------------------------------
module cps_back
    import cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cps_stage_t  stage_in,
    output logic        advance,
    cps_out_if.source   result
);

    logic [RATE_BITS-1:0]               rate;
    logic                               mvalid_reg;
    logic [2:0][COORD_BITS-1:0]         mstart_reg;
    logic [2:0][MUL_BITS-1:0]           mprod_reg;
    logic [2:0][MUL_BITS-1:0]           mprod_next;
    logic [RATE_BITS-1:0]               mrate_reg;
    logic                               monseg_reg;
    logic                               mdegen_reg;

    logic [2:0][MUL_BITS-1:0]           rounded;
    logic [2:0][COORD_BITS-1:0]         near_next;
    logic                               valid_reg;
    logic [2:0][COORD_BITS-1:0]         near_reg;
    logic [RATE_BITS-1:0]               rate_reg;
    logic                               onseg_reg;
    logic                               degen_reg;

    assign advance = !valid_reg || result.ready;

    always_comb
    begin
        unique case (stage_in.sel)
            SEL_ZERO: rate = RATE_ZERO;
            SEL_ONE:  rate = RATE_ONE;
            SEL_DIV:  rate = {1'b0, stage_in.quo};
            default:  rate = RATE_ZERO;
        endcase
        for (int i = 0; i < 3; i++)
            mprod_next[i] = MUL_BITS'($signed(stage_in.diff[i]) * $signed({1'b0, rate}));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rounded[i]   = MUL_BITS'($signed(mprod_reg[i] + ROUND_HALF) >>> RATE_FRAC_BITS);
            near_next[i] = mstart_reg[i] + rounded[i][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mvalid_reg <= stage_in.valid;
            valid_reg  <= mvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mstart_reg <= stage_in.start;
            mprod_reg  <= mprod_next;
            mrate_reg  <= rate;
            monseg_reg <= stage_in.on_segment;
            mdegen_reg <= stage_in.degenerate;
            near_reg   <= near_next;
            rate_reg   <= mrate_reg;
            onseg_reg  <= monseg_reg;
            degen_reg  <= mdegen_reg;
        end
    end

    assign result.valid        = valid_reg;
    assign result.near_x       = near_reg[0];
    assign result.near_y       = near_reg[1];
    assign result.near_z       = near_reg[2];
    assign result.clamped_rate = rate_reg;
    assign result.on_segment   = onseg_reg;
    assign result.degenerate   = degen_reg;

endmodule

// ===== src/closest_point_on_segment.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// closest_point_on_segment: nearest point on a 3D segment
//
// Channel   Role   Content
// query     sink   point, segment start and segment end, signed coordinates
// result    source nearest point, clamped Q1.16 rate, on_segment, degenerate
//
// One query is accepted in every cycle unless the chain holds; each result passes through
// three front stages, one cell per quotient bit in the divider chain (16),
// and a scaling stage plus the output register.
// Reset clears only the valid bits of the stages.
// When the output register holds a result that is not taken, the whole chain
// holds and the query channel is not ready.
// ---------------------------------------------------------------------------
module closest_point_on_segment
    import cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cps_in_if.sink      query,
    cps_out_if.source   result
);

    logic       advance;
    cps_stage_t chain [0:RATE_FRAC_BITS];

    cps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .query     (query),
        .stage_out (chain[0])
    );

    for (genvar g = 0; g < RATE_FRAC_BITS; g++)
    begin : g_cell
        cps_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    cps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (chain[RATE_FRAC_BITS]),
        .advance  (advance),
        .result   (result)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for closest_point_on_segment
// Sends directed and random segment queries over the query channel. An
// in-bench model computes the expected nearest point, the clamped rate and
// the flags for each transfer, and a checker compares every result transfer
// with the oldest expected one. Both channels idle at random and the result
// side holds off for a long stretch so that the pipeline fills.
// ---------------------------------------------------------------------------
module tb_top;
    import cps_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  SETTLE_CYC  = 30;
    localparam int  IDLE_PCT    = 29;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HOLD_CYC    = 300;

    typedef struct {
        logic signed [COORD_BITS-1:0] pt [3];
        logic signed [COORD_BITS-1:0] st [3];
        logic signed [COORD_BITS-1:0] en [3];
    } seg_query_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] near [3];
        logic [RATE_BITS-1:0]         rate;
        logic                         on_seg;
        logic                         degen;
    } nearest_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   cycle_count;
    int   rx_hold_left;
    bit   tx_calm;
    bit   rx_calm;

    nearest_t pending_nearest [$];

    cps_in_if  query_if ();
    cps_out_if result_if ();

    closest_point_on_segment u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic nearest_t predict_nearest(input seg_query_t q);
        longint   st [3];
        longint   dv [3];
        longint   dot;
        longint   len2;
        longint   rate;
        longint   acc;
        nearest_t r;
        dot  = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            st[i] = longint'(q.st[i]);
            dv[i] = longint'(q.en[i]) - st[i];
            dot  += dv[i] * (longint'(q.pt[i]) - st[i]);
            len2 += dv[i] * dv[i];
        end
        r.degen  = (len2 == 0);
        r.on_seg = (len2 != 0) && (dot >= 0) && (dot <= len2);
        if (len2 == 0 || dot >= len2)
            rate = longint'(RATE_ONE);
        else if (dot <= 0)
            rate = 0;
        else
            rate = (dot <<< RATE_FRAC_BITS) / len2;
        r.rate = RATE_BITS'(rate);
        for (int i = 0; i < 3; i++)
        begin
            if (r.degen)
                r.near[i] = COORD_BITS'(st[i]);
            else
            begin
                acc = dv[i] * rate + (longint'(1) <<< (RATE_FRAC_BITS - 1));
                r.near[i] = COORD_BITS'(st[i] + (acc >>> RATE_FRAC_BITS));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        nearest_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_nearest.size() == 0)
            begin
                $display("[%0t] result transfer with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                want = pending_nearest.pop_front();
                if (result_if.near_x !== want.near[0])
                    report_mismatch("near_x", result_if.near_x, want.near[0]);
                if (result_if.near_y !== want.near[1])
                    report_mismatch("near_y", result_if.near_y, want.near[1]);
                if (result_if.near_z !== want.near[2])
                    report_mismatch("near_z", result_if.near_z, want.near[2]);
                if (result_if.clamped_rate !== want.rate)
                    report_mismatch("clamped_rate", result_if.clamped_rate, want.rate);
                if (result_if.on_segment !== want.on_seg)
                    report_mismatch("on_segment", result_if.on_segment, want.on_seg);
                if (result_if.degenerate !== want.degen)
                    report_mismatch("degenerate", result_if.degenerate, want.degen);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                rx_hold_left--;
            end
            else
                result_if.ready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_query(input seg_query_t q);
        while (!tx_calm && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            query_if.valid <= 1'b0;
        end
        @(negedge clk);
        query_if.valid       <= 1'b1;
        query_if.point_x     <= q.pt[0];
        query_if.point_y     <= q.pt[1];
        query_if.point_z     <= q.pt[2];
        query_if.seg_start_x <= q.st[0];
        query_if.seg_start_y <= q.st[1];
        query_if.seg_start_z <= q.st[2];
        query_if.seg_end_x   <= q.en[0];
        query_if.seg_end_y   <= q.en[1];
        query_if.seg_end_z   <= q.en[2];
        do
            @(posedge clk);
        while (!query_if.ready);
        pending_nearest.push_back(predict_nearest(q));
    endtask

    task automatic send_coords(input int px, input int py, input int pz,
                               input int sx, input int sy, input int sz,
                               input int ex, input int ey, input int ez);
        seg_query_t q;
        q.pt = '{COORD_BITS'(px), COORD_BITS'(py), COORD_BITS'(pz)};
        q.st = '{COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(sz)};
        q.en = '{COORD_BITS'(ex), COORD_BITS'(ey), COORD_BITS'(ez)};
        send_query(q);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        query_if.valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(posedge clk);
    endtask

    function automatic seg_query_t make_random_query();
        seg_query_t q;
        int         pick;
        int         frac;
        int         s;
        int         d;
        pick = $urandom_range(99);
        for (int i = 0; i < 3; i++)
        begin
            q.pt[i] = COORD_BITS'($urandom);
            q.st[i] = COORD_BITS'($urandom);
            q.en[i] = COORD_BITS'($urandom);
        end
        if (pick < 45)
        begin
            // Point placed near the segment so that most rates fall inside.
            frac = $urandom_range(1200) - 100;
            for (int i = 0; i < 3; i++)
            begin
                s = int'($urandom_range(32000)) - 16000;
                d = int'($urandom_range(32000)) - 16000 - s;
                q.st[i] = COORD_BITS'(s);
                q.en[i] = COORD_BITS'(s + d);
                q.pt[i] = COORD_BITS'(s + (d * frac) / 1000 + int'($urandom_range(64)) - 32);
            end
        end
        else if (pick < 60)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q.pt[i] = COORD_BITS'(int'($urandom_range(15)) - 8);
                q.st[i] = COORD_BITS'(int'($urandom_range(7)) - 4);
                q.en[i] = COORD_BITS'(int'($urandom_range(7)) - 4);
            end
        end
        else if (pick < 67)
            q.en = q.st;
        else if (pick < 75)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q.st[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                q.en[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                q.pt[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            end
        end
        return q;
    endfunction

    task automatic test_directed_extremes();
        send_coords( 32767,  32767,  32767, -32768, -32768, -32768,  32767,  32767,  32767);
        send_coords(-32768, -32768, -32768,  32767,  32767,  32767, -32768, -32768, -32768);
        send_coords( 32767, -32768,  32767, -32768,  32767, -32768,  32767, -32768, -32768);
        send_coords(-32768,  32767,      0,  32767, -32768,  32767, -32768,  32767, -32768);
        send_coords(     0,      0,      0, -32768,      0,  32767,  32767,      0, -32768);
        send_coords(-21846,  12345,   -999,   -123,  30000, -30000,  29999, -29999,  31111);
    endtask

    task automatic test_special_cases();
        // Zero-length segments at the origin and at both corners.
        send_coords(     0,      0,      0,      0,      0,      0,      0,      0,      0);
        send_coords(-32768, -32768, -32768,  32767,  32767,  32767,  32767,  32767,  32767);
        send_coords( 32767,  32767,  32767, -32768, -32768, -32768, -32768, -32768, -32768);
        // Before the start, exactly at the start, past the end, exactly at the end.
        send_coords(   -50,      7,      3,      0,      0,      0,    100,      0,      0);
        send_coords(     0,    100,   -100,      0,      0,      0,    100,      0,      0);
        send_coords(   200,      0,      0,      0,      0,      0,    100,      0,      0);
        send_coords(   100,      5,      5,      0,      0,      0,    100,      0,      0);
        send_coords(    33,      1,      1,      0,      0,      0,    100,      0,      0);
        // A rate of one half lands exactly on the rounding point.
        send_coords(     1,      0,      0,      0,      0,      0,      1,      1,      0);
        send_coords(    -1,      0,      0,      0,      0,      0,     -1,     -1,      0);
        send_coords(     0,      0,      1,      0,      0,      0,      1,      1,      1);
        send_coords(  -500,    -20,   4000,  -1000,     10,   3000,      0,    -50,   5000);
        wait_for_results();
    endtask

    task automatic test_backpressure_fill();
        tx_calm      = 1'b1;
        rx_hold_left = HOLD_CYC;
        for (int n = 0; n < 60; n++)
            send_query(make_random_query());
        tx_calm = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_queries(input int count);
        for (int n = 0; n < count; n++)
        begin
            tx_calm = (n >= count / 3) && (n < count / 3 + 150);
            rx_calm = tx_calm;
            send_query(make_random_query());
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        mismatches           = 0;
        cycle_count          = 0;
        rx_hold_left         = 0;
        tx_calm              = 1'b0;
        rx_calm              = 1'b0;
        rst_n                = 1'b0;
        query_if.valid       = 1'b0;
        query_if.point_x     = '0;
        query_if.point_y     = '0;
        query_if.point_z     = '0;
        query_if.seg_start_x = '0;
        query_if.seg_start_y = '0;
        query_if.seg_start_z = '0;
        query_if.seg_end_x   = '0;
        query_if.seg_end_y   = '0;
        query_if.seg_end_z   = '0;
        result_if.ready      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_special_cases();
        test_backpressure_fill();
        test_random_queries(222);
        test_random_queries(250);

        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0 && pending_nearest.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
